>>> rtl/alr_pkg.sv
package alr_pkg;

	localparam int COORD_BITS_DEF    = 8;
	localparam int FRACTION_BITS_DEF = 32;
	localparam int LEVEL_BITS_DEF    = 4;
	localparam int QUEUE_DEPTH_DEF   = 4;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_ADVANCE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_STRAIGHT = 2'd0,
		KIND_XMAJOR   = 2'd1,
		KIND_YMAJOR   = 2'd2
	} kind_t;

endpackage

>>> rtl/alr_queue.sv
module alr_queue #(
	parameter int WIDTH = 64,
	parameter int DEPTH = alr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             empty
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == DEPTH_C);
	assign empty     = (count_q == '0);
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count out of range");

endmodule

>>> rtl/alr_front.sv
module alr_front #(
	parameter int COORD_BITS    = alr_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = alr_pkg::FRACTION_BITS_DEF,
	parameter int CMD_W         = 5 * COORD_BITS + FRACTION_BITS + 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  action,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic                  push,
	output logic [CMD_W-1:0]      push_data,
	input  logic                  q_full
);

	localparam int C     = COORD_BITS;
	localparam int F     = FRACTION_BITS;
	localparam int CNT_W = $clog2(F);

	typedef struct packed {
		alr_pkg::op_t   op;
		logic [C-1:0]   x0;
		logic [C-1:0]   y0;
		logic [C-1:0]   x1;
		logic [C-1:0]   y1;
		logic           going_left;
		alr_pkg::kind_t kind;
		logic [C-1:0]   steps;
		logic [F-1:0]   incr;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH
	} state_t;

	state_t       st_q;
	cmd_t         cmd_in, hold_q, hold_out;
	logic [C-1:0] dx, dy, minor, major;
	logic [C-1:0] rem_q, major_q;
	logic [F-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [C:0]   trial;
	logic         trial_ge;
	logic         accept, direct;

	// order endpoints top to bottom and classify
	always_comb begin
		cmd_in    = '0;
		cmd_in.op = alr_pkg::op_t'(action);
		if (start_y > end_y) begin
			cmd_in.x0 = end_x;
			cmd_in.y0 = end_y;
			cmd_in.x1 = start_x;
			cmd_in.y1 = start_y;
		end else begin
			cmd_in.x0 = start_x;
			cmd_in.y0 = start_y;
			cmd_in.x1 = end_x;
			cmd_in.y1 = end_y;
		end
		cmd_in.going_left = (cmd_in.x1 < cmd_in.x0);
		dx = cmd_in.going_left ? (cmd_in.x0 - cmd_in.x1) : (cmd_in.x1 - cmd_in.x0);
		dy = cmd_in.y1 - cmd_in.y0;
		minor = '0;
		major = '0;
		if (dx == '0 || dy == '0 || dx == dy) begin
			cmd_in.kind  = alr_pkg::KIND_STRAIGHT;
			cmd_in.steps = (dx > dy) ? dx : dy;
		end else if (dy > dx) begin
			cmd_in.kind  = alr_pkg::KIND_YMAJOR;
			cmd_in.steps = dy;
			minor = dx;
			major = dy;
		end else begin
			cmd_in.kind  = alr_pkg::KIND_XMAJOR;
			cmd_in.steps = dx;
			minor = dy;
			major = dx;
		end
	end

	assign in_stall = (st_q != ST_IDLE) || q_full;
	assign accept   = in_valid && !in_stall;
	assign direct   = (cmd_in.op == alr_pkg::OP_ADVANCE) ||
	                  (cmd_in.kind == alr_pkg::KIND_STRAIGHT);

	always_comb begin
		hold_out      = hold_q;
		hold_out.incr = quo_q;
	end

	assign push      = (st_q == ST_IDLE && accept && direct) ||
	                   (st_q == ST_PUSH && !q_full);
	assign push_data = (st_q == ST_PUSH) ? hold_out : cmd_in;

	// restoring divide of minor*2^F by major, one quotient bit per cycle
	assign trial    = {rem_q, 1'b0};
	assign trial_ge = (trial >= {1'b0, major_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			hold_q  <= '0;
			rem_q   <= '0;
			major_q <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept && !direct) begin
						hold_q  <= cmd_in;
						rem_q   <= minor;
						major_q <= major;
						quo_q   <= '0;
						cnt_q   <= CNT_W'(F - 1);
						st_q    <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= trial_ge ? C'(trial - {1'b0, major_q}) : C'(trial);
					quo_q <= {quo_q[F-2:0], trial_ge};
					if (cnt_q == '0) begin
						st_q <= ST_PUSH;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_PUSH: begin
					if (!q_full) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_rem_below_major: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (rem_q < major_q))
		else $error("divider remainder not below divisor");
	a_div_push_weighted: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PUSH && push) |-> (hold_q.kind != alr_pkg::KIND_STRAIGHT))
		else $error("straight line went through divider");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PUSH) |-> (quo_q != '0))
		else $error("weighted line with zero increment");

endmodule

>>> rtl/alr_back.sv
module alr_back #(
	parameter int COORD_BITS    = alr_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = alr_pkg::FRACTION_BITS_DEF,
	parameter int LEVEL_BITS    = alr_pkg::LEVEL_BITS_DEF,
	parameter int CMD_W         = 5 * COORD_BITS + FRACTION_BITS + 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CMD_W-1:0]      q_data,
	input  logic                  q_empty,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  valid_res,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [LEVEL_BITS-1:0] pixel_level,
	output logic                  has_companion,
	output logic [COORD_BITS-1:0] companion_x,
	output logic [COORD_BITS-1:0] companion_y,
	output logic [LEVEL_BITS-1:0] companion_level,
	output logic                  last
);

	localparam int C = COORD_BITS;
	localparam int F = FRACTION_BITS;
	localparam int L = LEVEL_BITS;
	localparam logic [C-1:0] ONE_C = C'(1);
	localparam logic [L-1:0] FULL  = {L{1'b1}};

	typedef struct packed {
		alr_pkg::op_t   op;
		logic [C-1:0]   x0;
		logic [C-1:0]   y0;
		logic [C-1:0]   x1;
		logic [C-1:0]   y1;
		logic           going_left;
		alr_pkg::kind_t kind;
		logic [C-1:0]   steps;
		logic [F-1:0]   incr;
	} cmd_t;

	typedef struct packed {
		logic         valid;
		logic [C-1:0] px;
		logic [C-1:0] py;
		logic [L-1:0] plev;
		logic         comp;
		logic [C-1:0] cx;
		logic [C-1:0] cy;
		logic [L-1:0] clev;
		logic         last;
	} res_t;

	cmd_t cmd;
	res_t res, res_q;
	logic out_valid_q;

	logic           active_q, n_active;
	alr_pkg::kind_t kind_q, n_kind;
	logic [C-1:0]   col_q, row_q, tcol_q, trow_q, steps_q;
	logic [C-1:0]   n_col, n_row, n_tcol, n_trow, n_steps;
	logic           left_q, n_left;
	logic [F-1:0]   acc_q, inc_q, n_acc, n_inc;
	logic [F:0]     sum;
	logic [L-1:0]   weight;

	function automatic logic [C-1:0] col_step(input logic [C-1:0] c, input logic left);
		return left ? (c - ONE_C) : (c + ONE_C);
	endfunction

	assign cmd    = cmd_t'(q_data);
	assign pop    = !q_empty && (!out_valid_q || !out_stall);
	assign sum    = {1'b0, acc_q} + {1'b0, inc_q};
	assign weight = sum[F-1 -: L];

	always_comb begin
		n_active = active_q;
		n_kind   = kind_q;
		n_col    = col_q;
		n_row    = row_q;
		n_tcol   = tcol_q;
		n_trow   = trow_q;
		n_left   = left_q;
		n_steps  = steps_q;
		n_acc    = acc_q;
		n_inc    = inc_q;
		res      = '0;
		case (cmd.op)
			alr_pkg::OP_LOAD: begin
				n_active  = (cmd.steps != '0);
				n_kind    = cmd.kind;
				n_col     = cmd.x0;
				n_row     = cmd.y0;
				n_tcol    = cmd.x1;
				n_trow    = cmd.y1;
				n_left    = cmd.going_left;
				n_steps   = cmd.steps;
				n_acc     = '0;
				n_inc     = cmd.incr;
				res.valid = 1'b1;
				res.px    = cmd.x0;
				res.py    = cmd.y0;
				res.plev  = FULL;
				res.last  = (cmd.steps == '0);
			end
			alr_pkg::OP_ADVANCE: begin
				if (!active_q) begin
					res = '0;
				end else if (steps_q <= ONE_C) begin
					n_col     = tcol_q;
					n_row     = trow_q;
					n_steps   = '0;
					n_active  = 1'b0;
					res.valid = 1'b1;
					res.px    = tcol_q;
					res.py    = trow_q;
					res.plev  = FULL;
					res.last  = 1'b1;
				end else begin
					n_steps   = steps_q - ONE_C;
					res.valid = 1'b1;
					case (kind_q)
						alr_pkg::KIND_YMAJOR: begin
							n_acc    = sum[F-1:0];
							n_col    = sum[F] ? col_step(col_q, left_q) : col_q;
							n_row    = row_q + ONE_C;
							res.comp = 1'b1;
							res.cx   = col_step(n_col, left_q);
							res.cy   = n_row;
							res.clev = weight;
							res.plev = weight ^ FULL;
						end
						alr_pkg::KIND_XMAJOR: begin
							n_acc    = sum[F-1:0];
							n_row    = sum[F] ? (row_q + ONE_C) : row_q;
							n_col    = col_step(col_q, left_q);
							res.comp = 1'b1;
							res.cx   = n_col;
							res.cy   = n_row + ONE_C;
							res.clev = weight;
							res.plev = weight ^ FULL;
						end
						default: begin
							if (col_q != tcol_q) begin
								n_col = col_step(col_q, left_q);
							end
							if (row_q != trow_q) begin
								n_row = row_q + ONE_C;
							end
							res.plev = FULL;
						end
					endcase
					res.px = n_col;
					res.py = n_row;
				end
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_q       <= '0;
			active_q    <= 1'b0;
			kind_q      <= alr_pkg::KIND_STRAIGHT;
			col_q       <= '0;
			row_q       <= '0;
			tcol_q      <= '0;
			trow_q      <= '0;
			left_q      <= 1'b0;
			steps_q     <= '0;
			acc_q       <= '0;
			inc_q       <= '0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
			res_q       <= res;
			active_q    <= n_active;
			kind_q      <= n_kind;
			col_q       <= n_col;
			row_q       <= n_row;
			tcol_q      <= n_tcol;
			trow_q      <= n_trow;
			left_q      <= n_left;
			steps_q     <= n_steps;
			acc_q       <= n_acc;
			inc_q       <= n_inc;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign valid_res       = res_q.valid;
	assign pixel_x         = res_q.px;
	assign pixel_y         = res_q.py;
	assign pixel_level     = res_q.plev;
	assign has_companion   = res_q.comp;
	assign companion_x     = res_q.cx;
	assign companion_y     = res_q.cy;
	assign companion_level = res_q.clev;
	assign last            = res_q.last;

	a_active_steps: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (steps_q != '0))
		else $error("active line with no steps left");
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && res.last) |=> !active_q)
		else $error("line still active after last pixel");
	a_weighted_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && kind_q != alr_pkg::KIND_STRAIGHT) |-> (inc_q != '0))
		else $error("weighted line with zero increment");
	a_comp_weighted: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && res.comp) |-> (active_q && kind_q != alr_pkg::KIND_STRAIGHT))
		else $error("companion pixel on a straight line");

endmodule

>>> rtl/antialiased_line_rasterizer_top.sv
// Antialiased line stepper, 4-bit greyscale by default.
// Input channel (in_valid / in_stall): action 0 loads a line from start_x/y
// to end_x/y, action 1 advances one step. Every accepted word gives exactly
// one result word on the output channel (out_valid / out_stall), in order.
// A load answers with the top endpoint at full level; advances walk the line
// and flag last on the end pixel; an advance with no line gives valid_res 0.
// A word is registered in the queue and then in the output register before
// out_valid rises. Advances and loads of horizontal, vertical or diagonal
// lines go straight to the queue. A load of any other line holds in_stall
// high from its acceptance through the divide until its word is queued, so
// the next word waits for the divide to finish and the word to be queued.
// The step increment comes from a restoring divider, one quotient bit a cycle.
// Items already queued keep draining to the output during a divide.
// A 4-word queue separates the front end from the stepper, so a stalled
// receiver holds the output register and the queue fills before in_stall
// rises. Reset clears the queue, the output register and the line state.
module antialiased_line_rasterizer_top #(
	parameter int COORD_BITS    = alr_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = alr_pkg::FRACTION_BITS_DEF,
	parameter int LEVEL_BITS    = alr_pkg::LEVEL_BITS_DEF,
	parameter int QUEUE_DEPTH   = alr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  action,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  valid_res,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [LEVEL_BITS-1:0] pixel_level,
	output logic                  has_companion,
	output logic [COORD_BITS-1:0] companion_x,
	output logic [COORD_BITS-1:0] companion_y,
	output logic [LEVEL_BITS-1:0] companion_level,
	output logic                  last
);

	localparam int CMD_W = 5 * COORD_BITS + FRACTION_BITS + 4;

	logic             push, q_full, q_empty, pop;
	logic [CMD_W-1:0] push_data, q_data;

	alr_front #(
		.COORD_BITS   (COORD_BITS),
		.FRACTION_BITS(FRACTION_BITS),
		.CMD_W        (CMD_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.start_x  (start_x),
		.start_y  (start_y),
		.end_x    (end_x),
		.end_y    (end_y),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	alr_queue #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.head_data(q_data),
		.empty    (q_empty)
	);

	alr_back #(
		.COORD_BITS   (COORD_BITS),
		.FRACTION_BITS(FRACTION_BITS),
		.LEVEL_BITS   (LEVEL_BITS),
		.CMD_W        (CMD_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_data         (q_data),
		.q_empty        (q_empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.valid_res      (valid_res),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.pixel_level    (pixel_level),
		.has_companion  (has_companion),
		.companion_x    (companion_x),
		.companion_y    (companion_y),
		.companion_level(companion_level),
		.last           (last)
	);

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int CB = alr_pkg::COORD_BITS_DEF;
	localparam int FB = alr_pkg::FRACTION_BITS_DEF;
	localparam int LB = alr_pkg::LEVEL_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int WORDS_PER_PHASE = 334;

	typedef logic [CB-1:0] coord_t;
	typedef logic [LB-1:0] level_t;
	localparam level_t FULL_LEVEL = '1;

	typedef struct packed {
		logic   valid_res;
		coord_t px;
		coord_t py;
		level_t plev;
		logic   comp;
		coord_t cx;
		coord_t cy;
		level_t clev;
		logic   last;
	} pixel_word_t;

	// Wu line stepper prediction plus in-order compare of result words.
	class line_scoreboard;
		logic              active;
		alr_pkg::kind_t    kind;
		coord_t            cur_col, cur_row, tgt_col, tgt_row, steps;
		logic              leftward;
		logic [FB-1:0]     acc, inc;
		pixel_word_t       expected_words[$];
		int                errors;
		int                n_loads, n_weighted, n_ends, n_blank;

		function new();
			active = 1'b0;
			kind = alr_pkg::KIND_STRAIGHT;
			cur_col = '0;
			cur_row = '0;
			tgt_col = '0;
			tgt_row = '0;
			steps = '0;
			leftward = 1'b0;
			acc = '0;
			inc = '0;
			errors = 0;
			n_loads = 0;
			n_weighted = 0;
			n_ends = 0;
			n_blank = 0;
		endfunction

		function coord_t step_col(coord_t c);
			return leftward ? c - 1'b1 : c + 1'b1;
		endfunction

		function int outstanding();
			return expected_words.size();
		endfunction

		function void note_word(alr_pkg::op_t op, coord_t sx, coord_t sy, coord_t ex,
				coord_t ey);
			pixel_word_t w;
			coord_t      x0, y0, x1, y1, dx, dy, cx, cy;
			logic [63:0] quot;
			logic        carry;
			level_t      weight;
			w = '0;
			if (op == alr_pkg::OP_LOAD) begin
				// line always runs top to bottom
				if (sy > ey) begin
					x0 = ex; y0 = ey; x1 = sx; y1 = sy;
				end else begin
					x0 = sx; y0 = sy; x1 = ex; y1 = ey;
				end
				leftward = x1 < x0;
				dx = leftward ? x0 - x1 : x1 - x0;
				dy = y1 - y0;
				cur_col = x0;
				cur_row = y0;
				tgt_col = x1;
				tgt_row = y1;
				acc = '0;
				inc = '0;
				if (dx == 0 || dy == 0 || dx == dy) begin
					kind = alr_pkg::KIND_STRAIGHT;
					steps = (dx > dy) ? dx : dy;
				end else if (dy > dx) begin
					kind = alr_pkg::KIND_YMAJOR;
					steps = dy;
					quot = {{(64-CB-FB){1'b0}}, dx, {FB{1'b0}}} / {{(64-CB){1'b0}}, dy};
					inc = quot[FB-1:0];
				end else begin
					kind = alr_pkg::KIND_XMAJOR;
					steps = dx;
					quot = {{(64-CB-FB){1'b0}}, dy, {FB{1'b0}}} / {{(64-CB){1'b0}}, dx};
					inc = quot[FB-1:0];
				end
				active = steps != 0;
				w.valid_res = 1'b1;
				w.px = x0;
				w.py = y0;
				w.plev = FULL_LEVEL;
				w.last = !active;
				n_loads++;
			end else if (!active) begin
				n_blank++;
			end else if (steps <= 1) begin
				cur_col = tgt_col;
				cur_row = tgt_row;
				steps = '0;
				active = 1'b0;
				w.valid_res = 1'b1;
				w.px = tgt_col;
				w.py = tgt_row;
				w.plev = FULL_LEVEL;
				w.last = 1'b1;
			end else begin
				steps--;
				if (kind == alr_pkg::KIND_XMAJOR || kind == alr_pkg::KIND_YMAJOR) begin
					{carry, acc} = {1'b0, acc} + {1'b0, inc};
					weight = acc[FB-1 -: LB];
					if (kind == alr_pkg::KIND_YMAJOR) begin
						if (carry)
							cur_col = step_col(cur_col);
						cur_row = cur_row + 1'b1;
						cx = step_col(cur_col);
						cy = cur_row;
					end else begin
						if (carry)
							cur_row = cur_row + 1'b1;
						cur_col = step_col(cur_col);
						cx = cur_col;
						cy = cur_row + 1'b1;
					end
					w.valid_res = 1'b1;
					w.px = cur_col;
					w.py = cur_row;
					w.plev = weight ^ FULL_LEVEL;
					w.comp = 1'b1;
					w.cx = cx;
					w.cy = cy;
					w.clev = weight;
					n_weighted++;
				end else begin
					if (cur_col != tgt_col)
						cur_col = step_col(cur_col);
					if (cur_row != tgt_row)
						cur_row = cur_row + 1'b1;
					w.valid_res = 1'b1;
					w.px = cur_col;
					w.py = cur_row;
					w.plev = FULL_LEVEL;
				end
			end
			if (w.last)
				n_ends++;
			expected_words.push_back(w);
		endfunction

		function string describe(pixel_word_t w);
			return $sformatf("v%0d (%0d,%0d) lev %0d comp %0d (%0d,%0d) lev %0d last %0d",
				w.valid_res, w.px, w.py, w.plev, w.comp, w.cx, w.cy, w.clev, w.last);
		endfunction

		function void check_word(pixel_word_t got);
			pixel_word_t want;
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result word with nothing pending: %s", $time, describe(got));
			end else begin
				want = expected_words.pop_front();
				if (got.valid_res !== want.valid_res || got.px !== want.px ||
						got.py !== want.py || got.plev !== want.plev ||
						got.comp !== want.comp || got.cx !== want.cx ||
						got.cy !== want.cy || got.clev !== want.clev ||
						got.last !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("%0t: mismatch\n  expected %s\n  actual   %s",
							$time, describe(want), describe(got));
				end
			end
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	logic   action = alr_pkg::OP_LOAD;
	coord_t start_x = '0;
	coord_t start_y = '0;
	coord_t end_x = '0;
	coord_t end_y = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	logic   valid_res;
	coord_t pixel_x, pixel_y, companion_x, companion_y;
	level_t pixel_level, companion_level;
	logic   has_companion;
	logic   last;

	line_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int words_sent = 0;
	int quiet_cycles = 0;

	antialiased_line_rasterizer_top u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.start_x         (start_x),
		.start_y         (start_y),
		.end_x           (end_x),
		.end_y           (end_y),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.valid_res       (valid_res),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.pixel_level     (pixel_level),
		.has_companion   (has_companion),
		.companion_x     (companion_x),
		.companion_y     (companion_y),
		.companion_level (companion_level),
		.last            (last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin : result_side
		pixel_word_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {valid_res, pixel_x, pixel_y, pixel_level, has_companion,
				companion_x, companion_y, companion_level, last};
			sb.check_word(got);
		end
		out_stall <= arst_n && ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
				$display("antialiased_line_rasterizer_top test failed");
				$finish;
			end
		end
	end

	task automatic send_word(input alr_pkg::op_t op, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= op;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		do @(posedge clk); while (in_stall);
		sb.note_word(op, sx, sy, ex, ey);
		words_sent++;
	endtask

	task automatic send_load(input coord_t x0, input coord_t y0, input coord_t x1,
			input coord_t y1);
		send_word(alr_pkg::OP_LOAD, x0, y0, x1, y1);
	endtask

	// coordinates are don't-care on an advance, so toggle them anyway
	task automatic send_advance();
		send_word(alr_pkg::OP_ADVANCE, coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), coord_t'($urandom));
	endtask

	// hold the input off until every pending word is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	function automatic coord_t near(coord_t v);
		return coord_t'($urandom_range(v < 8 ? 0 : v - 8, v > 247 ? 255 : v + 8));
	endfunction

	// mostly short lines walked to the end, some long ones, some cut short by
	// a reload, and a few stray advances
	task automatic random_line();
		int     pick, len, n_steps;
		coord_t x0, y0, x1, y1, dx, dy;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			send_advance();
		end else begin
			x0 = coord_t'($urandom);
			y0 = coord_t'($urandom);
			if (pick < 10) begin
				x1 = coord_t'($urandom);
				y1 = coord_t'($urandom);
			end else begin
				x1 = near(x0);
				y1 = near(y0);
				case ($urandom_range(0, 5))
					0: x1 = x0;
					1: y1 = y0;
					2: begin
						dy = (y1 > y0) ? y1 - y0 : y0 - y1;
						if ((x0 >= dy && $urandom_range(0, 1)) || x0 > 255 - dy)
							x1 = x0 - dy;
						else
							x1 = x0 + dy;
					end
					default: ;
				endcase
			end
			dx = (x1 > x0) ? x1 - x0 : x0 - x1;
			dy = (y1 > y0) ? y1 - y0 : y0 - y1;
			len = (dx > dy) ? int'(dx) : int'(dy);
			n_steps = len + $urandom_range(0, 1);
			if ($urandom_range(0, 9) == 0)
				n_steps = $urandom_range(0, len);
			send_load(x0, y0, x1, y1);
			repeat (n_steps) send_advance();
		end
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 60 : 0;
			recv_stall_pct = (ph == 0) ? 60 : (ph == 1) ? 10 : 0;
			if (ph == 0) begin
				// advance before any line
				send_advance();
				// single point line, then advance past it
				send_load(8'd255, 8'd0, 8'd255, 8'd0);
				send_advance();
				// horizontal, leftward
				send_load(8'd3, 8'd10, 8'd0, 8'd10);
				repeat (3) send_advance();
				// vertical, given bottom to top
				send_load(8'd7, 8'd255, 8'd7, 8'd252);
				repeat (3) send_advance();
				// diagonal
				send_load(8'd0, 8'd0, 8'd4, 8'd4);
				repeat (4) send_advance();
				// steep line dropped midway by a new shallow leftward one
				send_load(8'd10, 8'd20, 8'd13, 8'd30);
				repeat (2) send_advance();
				send_load(8'd200, 8'd5, 8'd190, 8'd8);
				repeat (4) send_advance();
			end
			while (words_sent < (ph + 1) * WORDS_PER_PHASE)
				random_line();
			drain();
		end

		repeat (16) @(posedge clk);
		$display("%0d words: %0d line loads, %0d weighted steps, %0d end pixels,",
			words_sent, sb.n_loads, sb.n_weighted, sb.n_ends);
		$display("%0d advances with no line; three stall mixes on both sides",
			sb.n_blank);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("antialiased_line_rasterizer_top test passed");
		else
			$display("antialiased_line_rasterizer_top test failed");
		$finish;
	end

endmodule
